FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both forms take the clock and the active-low reset so that every check is
// held off while the block is in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define CHK_PROP(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("property check failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define CHK_NEVER(label, clk_sig, rstn_sig, expr) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
        else $error("forbidden condition seen");

`else

`define CHK_PROP(label, clk_sig, rstn_sig, prop)

`define CHK_NEVER(label, clk_sig, rstn_sig, expr)

`endif

`endif

FILE: rtl/mipoff_pkg.sv
package mipoff_pkg;

    // Field widths
    localparam int MipW   = 5;
    localparam int CntW   = 16;
    localparam int BppW   = 8;
    localparam int DataW  = 32;
    localparam int AddrW  = 5;
    localparam int RegIdxW = 3;

    // Shared multiplier: 35-bit operand a, 32-bit operand b, low 35 bits kept.
    // Three bits above the 32-bit window keep the byte count exact before /8.
    localparam int ProdW  = 35;
    localparam int MulBW  = 32;

    // Mip levels the level counter is sized for
    localparam int MaxMips = 32;
    localparam int LvlW    = $clog2(MaxMips);

    // Register indexes on the configuration port
    localparam logic [RegIdxW-1:0] REG_BPP        = 3'd0;
    localparam logic [RegIdxW-1:0] REG_COMPRESSED = 3'd1;
    localparam logic [RegIdxW-1:0] REG_MIP_COUNT  = 3'd2;
    localparam logic [RegIdxW-1:0] REG_FRAMES     = 3'd3;
    localparam logic [RegIdxW-1:0] REG_FACES      = 3'd4;
    localparam logic [RegIdxW-1:0] REG_WIDTH      = 3'd5;
    localparam logic [RegIdxW-1:0] REG_HEIGHT     = 3'd6;
    localparam logic [RegIdxW-1:0] REG_SLICES     = 3'd7;

    // Request functions
    localparam logic FUNC_LOCATE = 1'b0;
    localparam logic FUNC_TOTAL  = 1'b1;

    typedef struct packed {
        logic            func;
        logic [MipW-1:0] mip_level;
        logic [CntW-1:0] frame_index;
        logic [CntW-1:0] face_index;
        logic [CntW-1:0] slice_index;
    } req_t;

    typedef struct packed {
        logic [DataW-1:0] byte_offset;
        logic [DataW-1:0] byte_length;
        logic             found;
    } rsp_t;

    typedef struct packed {
        logic [BppW-1:0] bits_per_pixel;
        logic            block_compressed;
        logic [MipW-1:0] mip_count;
        logic [CntW-1:0] frame_count;
        logic [CntW-1:0] face_count;
        logic [CntW-1:0] image_width;
        logic [CntW-1:0] image_height;
        logic [CntW-1:0] slice_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        bits_per_pixel:   8'd32,
        block_compressed: 1'b0,
        mip_count:        5'd1,
        frame_count:      16'd1,
        face_count:       16'd1,
        image_width:      16'd1,
        image_height:     16'd1,
        slice_count:      16'd1
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IMG0,
        ST_IMG1,
        ST_BEF0,
        ST_BEF1,
        ST_BEF2,
        ST_BEF3,
        ST_DIM,
        ST_SLC,
        ST_BPP,
        ST_SC1,
        ST_SC2,
        ST_ACC,
        ST_DONE
    } seq_state_t;

endpackage

FILE: rtl/mip_chain_offset_calc.sv
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_stall      mipoff_pkg::req_t
// rsp       out        rsp_valid / rsp_stall      mipoff_pkg::rsp_t
// apb       in/out     psel penable pwrite pready paddr pwdata prdata
//
// A request first counts the images of a level and those ahead of the one
// asked for, then walks the levels; in an in-range locate each level below
// it only halves the dimensions. All steps share the single 35x32 multiplier.
// A new request is taken once the sequencer is back in idle; the result
// register lets the next request start while the last result waits.
// Reset clears the sequencer and the result valid and loads the register
// defaults; a stalled result holds in its register and the sequencer waits.
`include "assert_macros.svh"

module mip_chain_offset_calc
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  mipoff_pkg::req_t                req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output mipoff_pkg::rsp_t                rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mipoff_pkg::AddrW-1:0]    paddr,
    input  logic [mipoff_pkg::DataW-1:0]    pwdata,
    output logic [mipoff_pkg::DataW-1:0]    prdata,
    output logic                            pready
);

    localparam int ProdW = mipoff_pkg::ProdW;
    localparam int MulBW = mipoff_pkg::MulBW;
    localparam int DataW = mipoff_pkg::DataW;
    localparam int CntW  = mipoff_pkg::CntW;
    localparam int LvlW  = mipoff_pkg::LvlW;
    localparam int BlkW  = CntW - 1;

    mipoff_pkg::cfg_t cfg;

    mipoff_pkg::seq_state_t state_reg;
    mipoff_pkg::seq_state_t state_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    mipoff_pkg::rsp_t       rsp_reg;
    mipoff_pkg::rsp_t       rsp_next;

    mipoff_pkg::req_t       req_reg;
    mipoff_pkg::req_t       req_next;
    logic                   found_reg;
    logic                   found_next;
    logic [LvlW-1:0]        lvl_reg;
    logic [LvlW-1:0]        lvl_next;
    logic [CntW-1:0]        w_reg;
    logic [CntW-1:0]        w_next;
    logic [CntW-1:0]        h_reg;
    logic [CntW-1:0]        h_next;
    logic [DataW-1:0]       img_reg;
    logic [DataW-1:0]       img_next;
    logic [DataW-1:0]       tmp_reg;
    logic [DataW-1:0]       tmp_next;
    logic [DataW-1:0]       bef_reg;
    logic [DataW-1:0]       bef_next;
    logic [DataW-1:0]       off_reg;
    logic [DataW-1:0]       off_next;
    logic [DataW-1:0]       len_reg;
    logic [DataW-1:0]       len_next;

    logic [ProdW-1:0]       mul_a;
    logic [MulBW-1:0]       mul_b;
    logic [ProdW-1:0]       prod;

    logic                   req_take;
    logic                   in_range;
    logic                   hit;
    logic                   skip;
    logic                   last_lvl;
    logic [CntW:0]          w_half;
    logic [CntW:0]          h_half;
    logic [CntW:0]          w_blk_sum;
    logic [CntW:0]          h_blk_sum;
    logic [BlkW-1:0]        w_blk;
    logic [BlkW-1:0]        h_blk;
    logic [DataW-1:0]       lvl_size;

    mipoff_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mipoff_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign pready    = 1'b1;
    assign req_stall = (state_reg != mipoff_pkg::ST_IDLE);
    assign req_take  = req_valid && !req_stall;

    // Range check of an incoming request
    assign in_range = (req.mip_level < cfg.mip_count) &&
                      (req.frame_index < cfg.frame_count) &&
                      (req.face_index < cfg.face_count) &&
                      (req.slice_index < cfg.slice_count);

    // Level walk conditions
    assign hit      = (req_reg.func == mipoff_pkg::FUNC_LOCATE) && found_reg &&
                      (lvl_reg == req_reg.mip_level);
    assign skip     = (req_reg.func == mipoff_pkg::FUNC_LOCATE) && found_reg &&
                      (lvl_reg < req_reg.mip_level);
    assign last_lvl = (lvl_reg == (cfg.mip_count - 5'd1));

    // Next level dimensions: ceiling of half
    assign w_half = {1'b0, w_reg} + 17'd1;
    assign h_half = {1'b0, h_reg} + 17'd1;

    // Block counts for compressed formats, at least one block
    assign w_blk_sum = {1'b0, w_reg} + 17'd3;
    assign h_blk_sum = {1'b0, h_reg} + 17'd3;
    assign w_blk = (w_blk_sum[CntW:2] == '0) ? BlkW'(1) : w_blk_sum[CntW:2];
    assign h_blk = (h_blk_sum[CntW:2] == '0) ? BlkW'(1) : h_blk_sum[CntW:2];

    // Level size in bytes from the bit count product
    assign lvl_size = cfg.block_compressed ? {prod[DataW-2:0], 1'b0}
                                           : prod[DataW+2:3];

    // Sequencer and datapath control
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        req_next       = req_reg;
        found_next     = found_reg;
        lvl_next       = lvl_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        img_next       = img_reg;
        tmp_next       = tmp_reg;
        bef_next       = bef_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            mipoff_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    req_next   = req;
                    found_next = (req.func == mipoff_pkg::FUNC_TOTAL) || in_range;
                    lvl_next   = '0;
                    w_next     = cfg.image_width;
                    h_next     = cfg.image_height;
                    off_next   = '0;
                    len_next   = '0;
                    state_next = mipoff_pkg::ST_IMG0;
                end
            end

            // Images per level: frames * faces * slices
            mipoff_pkg::ST_IMG0:
            begin
                mul_a      = ProdW'(cfg.frame_count);
                mul_b      = MulBW'(cfg.face_count);
                state_next = mipoff_pkg::ST_IMG1;
            end

            mipoff_pkg::ST_IMG1:
            begin
                mul_a      = prod;
                mul_b      = MulBW'(cfg.slice_count);
                state_next = mipoff_pkg::ST_BEF0;
            end

            // Images ahead of the one asked for inside its level
            mipoff_pkg::ST_BEF0:
            begin
                img_next   = prod[DataW-1:0];
                mul_a      = ProdW'(req_reg.frame_index);
                mul_b      = MulBW'(cfg.face_count);
                state_next = mipoff_pkg::ST_BEF1;
            end

            mipoff_pkg::ST_BEF1:
            begin
                mul_a      = prod;
                mul_b      = MulBW'(cfg.slice_count);
                state_next = mipoff_pkg::ST_BEF2;
            end

            mipoff_pkg::ST_BEF2:
            begin
                tmp_next   = prod[DataW-1:0];
                mul_a      = ProdW'(req_reg.face_index);
                mul_b      = MulBW'(cfg.slice_count);
                state_next = mipoff_pkg::ST_BEF3;
            end

            mipoff_pkg::ST_BEF3:
            begin
                bef_next = tmp_reg + prod[DataW-1:0] + DataW'(req_reg.slice_index);
                if (cfg.mip_count == '0)
                begin
                    state_next = mipoff_pkg::ST_DONE;
                end
                else
                begin
                    state_next = mipoff_pkg::ST_DIM;
                end
            end

            // Pixels or blocks of one slice of the current level
            mipoff_pkg::ST_DIM:
            begin
                if (cfg.block_compressed)
                begin
                    mul_a = ProdW'(w_blk);
                    mul_b = MulBW'(h_blk);
                end
                else
                begin
                    mul_a = ProdW'(w_reg);
                    mul_b = MulBW'(h_reg);
                end
                if (skip)
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    w_next     = w_half[CntW:1];
                    h_next     = h_half[CntW:1];
                end
                else
                begin
                    state_next = mipoff_pkg::ST_SLC;
                end
            end

            mipoff_pkg::ST_SLC:
            begin
                mul_a = prod;
                if (req_reg.func == mipoff_pkg::FUNC_TOTAL)
                begin
                    mul_b = MulBW'(cfg.slice_count);
                end
                else
                begin
                    mul_b = MulBW'(1);
                end
                state_next = mipoff_pkg::ST_BPP;
            end

            mipoff_pkg::ST_BPP:
            begin
                mul_a      = prod;
                mul_b      = MulBW'(cfg.bits_per_pixel);
                state_next = mipoff_pkg::ST_SC1;
            end

            // Scale the level size by the image count that applies
            mipoff_pkg::ST_SC1:
            begin
                mul_a = ProdW'(lvl_size);
                if (req_reg.func == mipoff_pkg::FUNC_TOTAL)
                begin
                    mul_b      = MulBW'(cfg.frame_count);
                    state_next = mipoff_pkg::ST_SC2;
                end
                else if (hit)
                begin
                    len_next   = lvl_size;
                    mul_b      = bef_reg;
                    state_next = mipoff_pkg::ST_ACC;
                end
                else
                begin
                    mul_b      = img_reg;
                    state_next = mipoff_pkg::ST_ACC;
                end
            end

            mipoff_pkg::ST_SC2:
            begin
                mul_a      = prod;
                mul_b      = MulBW'(cfg.face_count);
                state_next = mipoff_pkg::ST_ACC;
            end

            // Accumulate, then advance to the next level or finish after the last one
            mipoff_pkg::ST_ACC:
            begin
                if (req_reg.func == mipoff_pkg::FUNC_TOTAL)
                begin
                    len_next = len_reg + prod[DataW-1:0];
                end
                else
                begin
                    off_next = off_reg + prod[DataW-1:0];
                end
                if (last_lvl)
                begin
                    state_next = mipoff_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    w_next     = w_half[CntW:1];
                    h_next     = h_half[CntW:1];
                    state_next = mipoff_pkg::ST_DIM;
                end
            end

            // Hand the transaction to the result register once it is free
            mipoff_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.byte_offset = off_reg;
                    rsp_next.byte_length = len_reg;
                    rsp_next.found       = found_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = mipoff_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mipoff_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mipoff_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        req_reg   <= req_next;
        found_reg <= found_next;
        lvl_reg   <= lvl_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        img_reg   <= img_next;
        tmp_reg   <= tmp_next;
        bef_reg   <= bef_next;
        off_reg   <= off_next;
        len_reg   <= len_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted request always starts the sequencer
    `CHK_PROP(a_take_starts, clk, rst_n, req_take |=> (state_reg == mipoff_pkg::ST_IMG0))

    // The sequencer leaves idle only on an accepted request
    `CHK_PROP(a_idle_holds, clk, rst_n, (!req_stall && !req_valid) |=> !req_stall)

    // A new result comes only out of the done state
    `CHK_PROP(a_rsp_done, clk, rst_n, $rose(rsp_valid) |-> $past(state_reg == mipoff_pkg::ST_DONE))

    // An image outside the stored set never reports a length
    `CHK_NEVER(a_miss_no_len, clk, rst_n, rsp_valid && !rsp.found && (rsp.byte_length != '0))

endmodule

FILE: rtl/mipoff_mul.sv
module mipoff_mul
(
    input  logic                            clk,
    input  logic [mipoff_pkg::ProdW-1:0]    a,
    input  logic [mipoff_pkg::MulBW-1:0]    b,
    output logic [mipoff_pkg::ProdW-1:0]    p
);

    localparam int ProdW = mipoff_pkg::ProdW;

    logic [ProdW-1:0] p_next;
    logic [ProdW-1:0] p_reg;

    // Multiply modulo 2^ProdW
    assign p_next = a * ProdW'(b);

    // Register the product before it is used again
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

FILE: rtl/mipoff_regs.sv
module mipoff_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mipoff_pkg::AddrW-1:0]    paddr,
    input  logic [mipoff_pkg::DataW-1:0]    pwdata,
    output logic [mipoff_pkg::DataW-1:0]    prdata,
    output mipoff_pkg::cfg_t                cfg
);

    localparam int DataW = mipoff_pkg::DataW;

    mipoff_pkg::cfg_t cfg_reg;
    mipoff_pkg::cfg_t cfg_next;
    logic [mipoff_pkg::RegIdxW-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[mipoff_pkg::AddrW-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Update the addressed register on the access phase of a write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mipoff_pkg::REG_BPP:        cfg_next.bits_per_pixel   = pwdata[7:0];
                mipoff_pkg::REG_COMPRESSED: cfg_next.block_compressed = pwdata[0];
                mipoff_pkg::REG_MIP_COUNT:  cfg_next.mip_count        = pwdata[4:0];
                mipoff_pkg::REG_FRAMES:     cfg_next.frame_count      = pwdata[15:0];
                mipoff_pkg::REG_FACES:      cfg_next.face_count       = pwdata[15:0];
                mipoff_pkg::REG_WIDTH:      cfg_next.image_width      = pwdata[15:0];
                mipoff_pkg::REG_HEIGHT:     cfg_next.image_height     = pwdata[15:0];
                mipoff_pkg::REG_SLICES:     cfg_next.slice_count      = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= mipoff_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            mipoff_pkg::REG_BPP:        prdata = DataW'(cfg_reg.bits_per_pixel);
            mipoff_pkg::REG_COMPRESSED: prdata = DataW'(cfg_reg.block_compressed);
            mipoff_pkg::REG_MIP_COUNT:  prdata = DataW'(cfg_reg.mip_count);
            mipoff_pkg::REG_FRAMES:     prdata = DataW'(cfg_reg.frame_count);
            mipoff_pkg::REG_FACES:      prdata = DataW'(cfg_reg.face_count);
            mipoff_pkg::REG_WIDTH:      prdata = DataW'(cfg_reg.image_width);
            mipoff_pkg::REG_HEIGHT:     prdata = DataW'(cfg_reg.image_height);
            mipoff_pkg::REG_SLICES:     prdata = DataW'(cfg_reg.slice_count);
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
